FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the lattice triangle checkers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lttic_pkg.sv
// ---------------------------------------------------------------------------
// lttic_pkg
// widths, control word format and microcode table for the lattice triangle
// interior counter
// ---------------------------------------------------------------------------
package lttic_pkg;

  // coordinate width, range 4 to 31
  localparam int COORD_BITS = 16;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int AREA_W     = CROSS_W;
  localparam int BND_W      = MAG_W + 2;
  localparam int CNT_W      = AREA_W + 1;
  localparam int COUNT_W    = 32;
  localparam int EXT_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SHIFT_W    = $clog2(COORD_BITS + 2);
  localparam int IN_FIELDS  = 6;
  localparam int IN_DATA_W  = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = COUNT_W;
  localparam int OUT_USER_W = 2;

  // tuser bit positions on the result channel
  localparam int USER_DEGEN = 0;
  localparam int USER_ZERO  = 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic        [MAG_W-1:0]      mag_t;

  // gcd unit command and status
  typedef struct packed {
    logic start;
    mag_t a;
    mag_t b;
  } gcd_cmd_t;

  typedef struct packed {
    logic busy;
    mag_t g;
  } gcd_stat_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_MUL_A,
    OP_MUL_B,
    OP_CROSS,
    OP_GCD_E0,
    OP_GCD_E1,
    OP_GCD_E2,
    OP_GCD_RUN,
    OP_BND_ACC,
    OP_EMIT
  } uop_t;

  // jump conditions: jump to target when true, else fall through
  typedef enum logic [2:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_NO_IN,
    CND_GCD_BUSY,
    CND_OUT_BLOCKED
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD  = 4'd0;
  localparam step_t STEP_DIFF  = 4'd1;
  localparam step_t STEP_MUL_A = 4'd2;
  localparam step_t STEP_MUL_B = 4'd3;
  localparam step_t STEP_CROSS = 4'd4;
  localparam step_t STEP_G0    = 4'd5;
  localparam step_t STEP_R0    = 4'd6;
  localparam step_t STEP_A0    = 4'd7;
  localparam step_t STEP_G1    = 4'd8;
  localparam step_t STEP_R1    = 4'd9;
  localparam step_t STEP_A1    = 4'd10;
  localparam step_t STEP_G2    = 4'd11;
  localparam step_t STEP_R2    = 4'd12;
  localparam step_t STEP_A2    = 4'd13;
  localparam step_t STEP_EMIT  = 4'd14;
  localparam step_t STEP_WRAP  = 4'd15;

  typedef struct packed {
    uop_t  op;
    cond_t cnd;
    step_t target;
  } ucw_t;

  // microcode store
  function automatic ucw_t ucode_rom(input step_t step);
    ucw_t w;
    unique case (step)
      STEP_LOAD:  w = '{op: OP_LOAD,    cnd: CND_NO_IN,       target: STEP_LOAD};
      STEP_DIFF:  w = '{op: OP_DIFF,    cnd: CND_NONE,        target: STEP_LOAD};
      STEP_MUL_A: w = '{op: OP_MUL_A,   cnd: CND_NONE,        target: STEP_LOAD};
      STEP_MUL_B: w = '{op: OP_MUL_B,   cnd: CND_NONE,        target: STEP_LOAD};
      STEP_CROSS: w = '{op: OP_CROSS,   cnd: CND_NONE,        target: STEP_LOAD};
      STEP_G0:    w = '{op: OP_GCD_E0,  cnd: CND_NONE,        target: STEP_LOAD};
      STEP_R0:    w = '{op: OP_GCD_RUN, cnd: CND_GCD_BUSY,    target: STEP_R0};
      STEP_A0:    w = '{op: OP_BND_ACC, cnd: CND_NONE,        target: STEP_LOAD};
      STEP_G1:    w = '{op: OP_GCD_E1,  cnd: CND_NONE,        target: STEP_LOAD};
      STEP_R1:    w = '{op: OP_GCD_RUN, cnd: CND_GCD_BUSY,    target: STEP_R1};
      STEP_A1:    w = '{op: OP_BND_ACC, cnd: CND_NONE,        target: STEP_LOAD};
      STEP_G2:    w = '{op: OP_GCD_E2,  cnd: CND_NONE,        target: STEP_LOAD};
      STEP_R2:    w = '{op: OP_GCD_RUN, cnd: CND_GCD_BUSY,    target: STEP_R2};
      STEP_A2:    w = '{op: OP_BND_ACC, cnd: CND_NONE,        target: STEP_LOAD};
      STEP_EMIT:  w = '{op: OP_EMIT,    cnd: CND_OUT_BLOCKED, target: STEP_EMIT};
      STEP_WRAP:  w = '{op: OP_NOP,     cnd: CND_ALWAYS,      target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/lttic_gcd.sv
// ---------------------------------------------------------------------------
// lttic_gcd
// binary gcd unit, one reduction step per cycle
// ---------------------------------------------------------------------------
module lttic_gcd (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lttic_pkg::gcd_cmd_t  cmd,
  output lttic_pkg::gcd_stat_t stat
);

  lttic_pkg::mag_t                   a_r, a_nxt;
  lttic_pkg::mag_t                   b_r, b_nxt;
  lttic_pkg::mag_t                   g_r, g_nxt;
  logic [lttic_pkg::SHIFT_W-1:0]     k_r, k_nxt;
  logic                              busy_r, busy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    g_r <= g_nxt;
    k_r <= k_nxt;
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      a_nxt    = cmd.a;
      b_nxt    = cmd.b;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      priority if (a_r == '0 || b_r == '0) begin
        // one side empty: the other, rescaled by common twos, is the gcd
        g_nxt    = (a_r | b_r) << k_r;
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + lttic_pkg::SHIFT_W'(1);
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.g    = g_r;

endmodule

FILE: rtl/lattice_triangle_interior_count.sv
// ---------------------------------------------------------------------------
// lattice_triangle_interior_count
// interior lattice point count of a triangle by pick's theorem, run by a
// microcoded sequencer over one multiplier and one binary gcd unit
// ---------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit first)              | tuser
//  --------+-----------+------------------------------------+-------------------
//  in_     | slave     | ax, ay, bx, by_coord, cx, cy (16b) | -
//  out_    | master    | interior_count (32b)               | degenerate, all_zero
//
//  one transaction in gives one transaction out; one item in flight at a time
//  steps per item: the load step, 12 fixed steps and three gcd wait steps, each
//  wait held while the gcd unit is busy with its reduction steps
//  reset is synchronous, active low, and returns the step counter to the load step
//  a stalled result holds the sequencer at emit; the next input waits until then
//
module lattice_triangle_interior_count (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // ax, ay, bx, by_coord, cx, cy
  input  logic [lttic_pkg::IN_DATA_W-1:0]      in_tdata,
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // interior_count
  output logic [lttic_pkg::OUT_DATA_W-1:0]     out_tdata,
  // degenerate, all_zero
  output logic [lttic_pkg::OUT_USER_W-1:0]     out_tuser
);

  localparam int CB = lttic_pkg::COORD_BITS;

  // sequencer
  lttic_pkg::step_t   step_r, step_nxt;
  lttic_pkg::ucw_t    ucw;
  logic               jump;
  logic               in_acc;
  logic               can_emit;
  logic               emit_fire;

  // datapath
  lttic_pkg::coord_t                    coord_r [lttic_pkg::IN_FIELDS];
  lttic_pkg::diff_t                     ux_r, uy_r, vx_r, vy_r;
  logic signed [lttic_pkg::PROD_W-1:0]  prod_r;
  logic signed [lttic_pkg::CROSS_W-1:0] cross_r;
  logic [lttic_pkg::BND_W-1:0]          bnd_r;
  logic [lttic_pkg::AREA_W-1:0]         area2;
  logic [lttic_pkg::CNT_W-1:0]          cnt;
  logic [lttic_pkg::EXT_W-1:0]          cnt_ext;
  logic [lttic_pkg::COUNT_W-1:0]        cnt_sat;
  logic                                 degen;
  logic                                 all_zero;

  // result register
  logic                                 out_valid_r;
  logic [lttic_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic [lttic_pkg::OUT_USER_W-1:0]     out_user_r;

  lttic_pkg::gcd_cmd_t                  gcd_cmd;
  lttic_pkg::gcd_stat_t                 gcd_stat;

  // magnitude of a coordinate difference
  function automatic lttic_pkg::mag_t mag_diff(input lttic_pkg::coord_t p,
                                               input lttic_pkg::coord_t q);
    lttic_pkg::diff_t d;
    d = lttic_pkg::diff_t'(p) - lttic_pkg::diff_t'(q);
    return d[lttic_pkg::DIFF_W-1] ? lttic_pkg::mag_t'(-d) : lttic_pkg::mag_t'(d);
  endfunction

  // ---------------------------------------------------------------- control
  assign ucw       = lttic_pkg::ucode_rom(step_r);
  assign in_tready = (ucw.op == lttic_pkg::OP_LOAD);
  assign in_acc    = in_tvalid & in_tready;
  assign can_emit  = !out_valid_r || out_tready;
  assign emit_fire = (ucw.op == lttic_pkg::OP_EMIT) && can_emit;

  always_comb begin
    unique case (ucw.cnd)
      lttic_pkg::CND_NONE:        jump = 1'b0;
      lttic_pkg::CND_ALWAYS:      jump = 1'b1;
      lttic_pkg::CND_NO_IN:       jump = !in_acc;
      lttic_pkg::CND_GCD_BUSY:    jump = gcd_stat.busy;
      lttic_pkg::CND_OUT_BLOCKED: jump = !can_emit;
      default:                    jump = 1'b0;
    endcase
    step_nxt = jump ? ucw.target : step_r + lttic_pkg::step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lttic_pkg::STEP_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

  // ---------------------------------------------------------------- gcd unit
  // edges in order a-b, b-c, c-a
  always_comb begin
    gcd_cmd = '0;
    unique case (ucw.op)
      lttic_pkg::OP_GCD_E0: begin
        gcd_cmd.start = 1'b1;
        gcd_cmd.a     = mag_diff(coord_r[0], coord_r[2]);
        gcd_cmd.b     = mag_diff(coord_r[1], coord_r[3]);
      end
      lttic_pkg::OP_GCD_E1: begin
        gcd_cmd.start = 1'b1;
        gcd_cmd.a     = mag_diff(coord_r[2], coord_r[4]);
        gcd_cmd.b     = mag_diff(coord_r[3], coord_r[5]);
      end
      lttic_pkg::OP_GCD_E2: begin
        gcd_cmd.start = 1'b1;
        gcd_cmd.a     = mag_diff(coord_r[4], coord_r[0]);
        gcd_cmd.b     = mag_diff(coord_r[5], coord_r[1]);
      end
      default: gcd_cmd = '0;
    endcase
  end

  lttic_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (gcd_cmd),
    .stat  (gcd_stat)
  );

  // ---------------------------------------------------------------- result
  // twice the area is the magnitude of the cross product
  assign area2    = cross_r[lttic_pkg::CROSS_W-1] ? lttic_pkg::AREA_W'(-cross_r)
                                                  : lttic_pkg::AREA_W'(cross_r);
  assign degen    = (cross_r == '0);
  assign all_zero = (coord_r[0] == '0) && (coord_r[1] == '0) && (coord_r[2] == '0) &&
                    (coord_r[3] == '0) && (coord_r[4] == '0) && (coord_r[5] == '0);
  // pick: (2A + 2 - B) / 2
  assign cnt      = (lttic_pkg::CNT_W'(area2) + lttic_pkg::CNT_W'(2)
                    - lttic_pkg::CNT_W'(bnd_r)) >> 1;
  assign cnt_ext  = lttic_pkg::EXT_W'(cnt);
  // saturate when wide coordinates push the count past 32 bits
  assign cnt_sat  = ((cnt_ext >> lttic_pkg::COUNT_W) != '0) ? '1
                                                            : cnt_ext[lttic_pkg::COUNT_W-1:0];

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (ucw.op)
      lttic_pkg::OP_LOAD: begin
        if (in_acc) begin
          for (int i = 0; i < lttic_pkg::IN_FIELDS; i++) begin
            coord_r[i] <= in_tdata[i*CB +: CB];
          end
        end
      end
      lttic_pkg::OP_DIFF: begin
        ux_r <= lttic_pkg::diff_t'(coord_r[2]) - lttic_pkg::diff_t'(coord_r[0]);
        uy_r <= lttic_pkg::diff_t'(coord_r[3]) - lttic_pkg::diff_t'(coord_r[1]);
        vx_r <= lttic_pkg::diff_t'(coord_r[4]) - lttic_pkg::diff_t'(coord_r[0]);
        vy_r <= lttic_pkg::diff_t'(coord_r[5]) - lttic_pkg::diff_t'(coord_r[1]);
      end
      lttic_pkg::OP_MUL_A: begin
        prod_r <= ux_r * vy_r;
      end
      lttic_pkg::OP_MUL_B: begin
        cross_r <= lttic_pkg::CROSS_W'(prod_r);
        prod_r  <= uy_r * vx_r;
      end
      lttic_pkg::OP_CROSS: begin
        cross_r <= cross_r - lttic_pkg::CROSS_W'(prod_r);
        bnd_r   <= '0;
      end
      lttic_pkg::OP_BND_ACC: begin
        bnd_r <= bnd_r + lttic_pkg::BND_W'(gcd_stat.g);
      end
      lttic_pkg::OP_EMIT: begin
        if (can_emit) begin
          out_data_r                        <= degen ? '0 : cnt_sat;
          out_user_r[lttic_pkg::USER_DEGEN] <= degen;
          out_user_r[lttic_pkg::USER_ZERO]  <= all_zero;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/lttic_checker.sv
// ---------------------------------------------------------------------------
// lttic_checker
// port-level checks for the lattice triangle interior counter
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lttic_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [lttic_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [lttic_pkg::OUT_USER_W-1:0]     out_tuser
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // one item at a time: no second transaction right after an accept
  `ASSERT_NEXT(a_in_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // the end marker is always collinear
  `ASSERT_IMPLY(a_zero_degen, clk, rst_n, out_tvalid && out_tuser[lttic_pkg::USER_ZERO], out_tuser[lttic_pkg::USER_DEGEN], "end marker not flagged degenerate")

  // a degenerate triple carries a zero count
  `ASSERT_IMPLY(a_degen_count, clk, rst_n, out_tvalid && out_tuser[lttic_pkg::USER_DEGEN], out_tdata == '0, "degenerate result with non-zero count")

endmodule

bind lattice_triangle_interior_count lttic_checker u_lttic_checker (.*);
